// ----- rtl/rbfa_pkg.sv -----
package rbfa_pkg;

  // queue and offset sizing
  localparam int QUEUE_DEPTH = 16;
  localparam int OFFSET_BITS = 32;
  localparam int DATA_W      = 32;
  localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  // compare width: wide enough for offset plus size without overflow
  localparam int CMP_W       = ((OFFSET_BITS > DATA_W) ? OFFSET_BITS : DATA_W) + 1;
  localparam logic [DATA_W-1:0] POOL_RESET = DATA_W'(1048576);

  typedef logic [SLOT_W-1:0]      slot_t;
  typedef logic [CNT_W-1:0]       count_t;
  typedef logic [OFFSET_BITS-1:0] offs_t;
  typedef logic [DATA_W-1:0]      data_t;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_WAIT      = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_IGNORED   = 3'd3,
    ST_MISMATCH  = 3'd4,
    ST_ORDER     = 3'd5,
    ST_FULL      = 3'd6
  } status_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic cfg_wr;
    logic capture;
    logic commit;
  } cmd_t;

  // circular slot index: base plus k, modulo the queue depth
  function automatic slot_t slot_add(slot_t base, count_t k);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(k);
    if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return slot_t'(sum);
  endfunction

endpackage

// ----- rtl/ring_buffer_fifo_allocator.sv -----
// channel   dir   handshake              payload
// in        in    in_valid / in_ready    in_operation, in_region_id, in_region_bytes
// out       out   out_valid / out_ready  out_status, out_offset, out_used_bytes
// cfg       in    cfg_valid / cfg_ready  cfg_pool_size
//
// each request runs in two steps: capture with the compare stage, then commit
// the id search over the live queue and the head and tail update set the two steps
// a new request is taken while the previous word still waits on the output
// commit holds while the output register is full and out_ready is low
// synchronous active-low reset: empty pool, pool size 1048576 bytes
module ring_buffer_fifo_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [31:0] in_region_id,
  input  logic [31:0] in_region_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_offset,
  output logic [31:0] out_used_bytes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_pool_size
);

  rbfa_pkg::cmd_t cmd;

  // controller
  rbfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  // datapath
  rbfa_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg_data   (cfg_pool_size),
    .in_op      (in_operation),
    .in_id      (in_region_id),
    .in_bytes   (in_region_bytes),
    .res_status (out_status),
    .res_offset (out_offset),
    .res_used   (out_used_bytes)
  );

  // one request in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a request is in flight");

  // offset is only nonzero for a successful allocate
  a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != rbfa_pkg::ST_OK) |-> out_offset == '0)
    else $error("nonzero offset on a failed request");

  // a new word is loaded only after a request was accepted
  a_word_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("output word without a request");

endmodule

// ----- rtl/rbfa_ctrl.sv -----
module rbfa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  output rbfa_pkg::cmd_t      cmd
);

  typedef enum logic {
    S_IDLE,
    S_COMMIT
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  // output register can take a word this cycle
  assign out_free  = !out_valid_r || out_ready;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;

  // commands
  always_comb begin
    cmd.cfg_wr  = cfg_valid;
    cmd.capture = in_valid && (state_r == S_IDLE);
    cmd.commit  = (state_r == S_COMMIT) && out_free;
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_COMMIT;
          end
          if (out_ready) begin
            out_valid_r <= 1'b0;
          end
        end
        S_COMMIT: begin
          if (out_free) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/rbfa_dpath.sv -----
module rbfa_dpath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rbfa_pkg::cmd_t             cmd,
  input  logic [31:0]                cfg_data,
  input  logic                       in_op,
  input  logic [31:0]                in_id,
  input  logic [31:0]                in_bytes,
  output logic [2:0]                 res_status,
  output logic [31:0]                res_offset,
  output logic [31:0]                res_used
);

  localparam int DEPTH = rbfa_pkg::QUEUE_DEPTH;
  localparam int OB    = rbfa_pkg::OFFSET_BITS;
  localparam int CW    = rbfa_pkg::CMP_W;
  localparam int NW    = rbfa_pkg::CNT_W;

  // allocator state
  rbfa_pkg::data_t  pool_r;
  rbfa_pkg::offs_t  head_r, tail_r;
  rbfa_pkg::data_t  used_r;
  rbfa_pkg::count_t count_r;
  rbfa_pkg::slot_t  oldest_r;

  // live region queue
  rbfa_pkg::data_t  ids_r   [DEPTH];
  rbfa_pkg::data_t  sizes_r [DEPTH];
  rbfa_pkg::offs_t  offs_r  [DEPTH];

  // first stage results
  logic             op_s_r;
  rbfa_pkg::data_t  id_s_r, sz_s_r;
  logic             too_large_s_r, full_s_r, no_room_s_r;
  logic             wrapped_s_r, fit_end_s_r, fit_gap_s_r, fit_zero_s_r;
  logic             id_zero_s_r;
  rbfa_pkg::offs_t  h_s_r, t_s_r;
  logic [DEPTH-1:0] match_s_r;

  // result word
  rbfa_pkg::status_t status_r;
  logic [31:0]       offset_r;
  rbfa_pkg::data_t   used_out_r;

  // first stage comb
  logic             empty;
  rbfa_pkg::offs_t  h_eff, t_eff;
  logic [CW-1:0]    h_ext, t_ext, sz_ext, pool_ext, hs_sum;
  logic [32:0]      used_sum;
  logic [DEPTH-1:0] match;

  assign empty    = (used_r == '0);
  assign h_eff    = empty ? '0 : head_r;
  assign t_eff    = empty ? '0 : tail_r;
  assign h_ext    = CW'(h_eff);
  assign t_ext    = CW'(t_eff);
  assign sz_ext   = CW'(in_bytes);
  assign pool_ext = CW'(pool_r);
  assign hs_sum   = h_ext + sz_ext;
  assign used_sum = {1'b0, used_r} + {1'b0, in_bytes};

  // id compare against every queue entry
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match[i] = (ids_r[i] == in_id);
    end
  end

  // capture request and first stage flags
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_s_r        <= in_op;
      id_s_r        <= in_id;
      sz_s_r        <= in_bytes;
      too_large_s_r <= (in_bytes > pool_r);
      full_s_r      <= (count_r >= NW'(DEPTH));
      no_room_s_r   <= (used_sum > {1'b0, pool_r});
      wrapped_s_r   <= (t_eff > h_eff) || ((t_eff == h_eff) && !empty);
      fit_end_s_r   <= (hs_sum <= pool_ext);
      fit_gap_s_r   <= (hs_sum <= t_ext);
      fit_zero_s_r  <= (sz_ext <= t_ext);
      id_zero_s_r   <= (in_id == '0);
      h_s_r         <= h_eff;
      t_s_r         <= t_eff;
      match_s_r     <= match;
    end
  end

  // live matches ordered from the oldest entry
  logic [DEPTH-1:0]  m_rel;
  logic              any_match;
  rbfa_pkg::slot_t   found_k;
  rbfa_pkg::slot_t   found_slot;
  logic              size_ok;

  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      m_rel[k] = (NW'(k) < count_r) &&
                 match_s_r[rbfa_pkg::slot_add(oldest_r, NW'(k))];
    end
  end

  // first match from the oldest
  always_comb begin
    found_k = '0;
    for (int k = DEPTH - 1; k >= 0; k--) begin
      if (m_rel[k]) begin
        found_k = rbfa_pkg::SLOT_W'(k);
      end
    end
  end

  assign any_match  = |m_rel;
  assign found_slot = rbfa_pkg::slot_add(oldest_r, NW'(found_k));
  assign size_ok    = (sizes_r[found_slot] == sz_s_r);

  // release arithmetic
  rbfa_pkg::offs_t new_tail;
  rbfa_pkg::data_t used_dec;
  assign new_tail = offs_r[oldest_r] + OB'(sz_s_r);
  assign used_dec = (used_r >= sz_s_r) ? (used_r - sz_s_r) : '0;

  // commit decision
  rbfa_pkg::offs_t   head_nxt, tail_nxt, at;
  rbfa_pkg::data_t   used_nxt;
  rbfa_pkg::count_t  count_nxt;
  rbfa_pkg::slot_t   oldest_nxt, wr_slot;
  rbfa_pkg::status_t status_nxt;
  logic [31:0]       offset_nxt;
  logic              place;

  assign wr_slot = rbfa_pkg::slot_add(oldest_r, count_r);

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    used_nxt   = used_r;
    count_nxt  = count_r;
    oldest_nxt = oldest_r;
    status_nxt = rbfa_pkg::ST_OK;
    place      = 1'b0;
    at         = h_s_r;
    if (op_s_r == rbfa_pkg::OP_ALLOC) begin
      if (too_large_s_r) begin
        status_nxt = rbfa_pkg::ST_TOO_LARGE;
      end else if (full_s_r) begin
        status_nxt = rbfa_pkg::ST_FULL;
      end else if (no_room_s_r) begin
        status_nxt = rbfa_pkg::ST_WAIT;
      end else begin
        head_nxt = h_s_r;
        tail_nxt = t_s_r;
        if (!wrapped_s_r && fit_end_s_r) begin
          place = 1'b1;
        end else if (!wrapped_s_r) begin
          // wrap the head to the start of the pool
          head_nxt = '0;
          at       = '0;
          if (fit_zero_s_r) begin
            place = 1'b1;
          end else begin
            status_nxt = rbfa_pkg::ST_WAIT;
          end
        end else if (fit_gap_s_r) begin
          place = 1'b1;
        end else begin
          status_nxt = rbfa_pkg::ST_WAIT;
        end
        if (place) begin
          head_nxt  = at + OB'(sz_s_r);
          used_nxt  = used_r + sz_s_r;
          count_nxt = count_r + NW'(1);
        end
      end
    end else begin
      if (id_zero_s_r || !any_match) begin
        status_nxt = rbfa_pkg::ST_IGNORED;
      end else if (!size_ok) begin
        status_nxt = rbfa_pkg::ST_MISMATCH;
      end else if (found_k != '0) begin
        status_nxt = rbfa_pkg::ST_ORDER;
      end else begin
        // pop the oldest region
        if (sz_s_r != '0) begin
          tail_nxt = new_tail;
        end
        used_nxt = used_dec;
        if (used_dec == '0) begin
          head_nxt = '0;
          tail_nxt = '0;
        end
        oldest_nxt = rbfa_pkg::slot_add(oldest_r, NW'(1));
        count_nxt  = count_r - NW'(1);
      end
    end
    offset_nxt = place ? 32'(CW'(at)) : '0;
  end

  // state registers and config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r   <= rbfa_pkg::POOL_RESET;
      head_r   <= '0;
      tail_r   <= '0;
      used_r   <= '0;
      count_r  <= '0;
      oldest_r <= '0;
    end else begin
      if (cmd.cfg_wr) begin
        pool_r <= cfg_data;
      end
      if (cmd.commit) begin
        head_r   <= head_nxt;
        tail_r   <= tail_nxt;
        used_r   <= used_nxt;
        count_r  <= count_nxt;
        oldest_r <= oldest_nxt;
      end
    end
  end

  // queue write
  always_ff @(posedge clk) begin
    if (cmd.commit && place) begin
      ids_r[wr_slot]   <= id_s_r;
      sizes_r[wr_slot] <= sz_s_r;
      offs_r[wr_slot]  <= at;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r   <= status_nxt;
      offset_r   <= offset_nxt;
      used_out_r <= used_nxt;
    end
  end

  assign res_status = status_r;
  assign res_offset = offset_r;
  assign res_used   = used_out_r;

endmodule
